[sv/record_list_deframer_unit_defines.svh]
// assertion macros used by the checker file
`ifndef RECORD_LIST_DEFRAMER_UNIT_DEFINES_SVH
`define RECORD_LIST_DEFRAMER_UNIT_DEFINES_SVH

// checked outside reset
`define RLD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked during reset too
`define RLD_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rld_pkg.sv]
package rld_pkg;

	localparam int MAX_BUFFER_BYTES = 65536;
	localparam int MAX_RECORDS      = 2048;

	localparam int LEN_W    = 17;
	localparam int CNT_W    = 12;
	localparam int IDX_W    = 11;
	localparam int HBC_W    = 5;
	localparam int END_W    = LEN_W + 1;
	localparam int CFG_W    = LEN_W;
	localparam int HDR_BYTES = 20;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic CFG_TOTAL_LENGTH = 1'b0;
	localparam logic CFG_RECORD_COUNT = 1'b1;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_SUCCESS = 2'd2,
		KIND_FAILURE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_DONE    = 3'b001,
		PH_HEADER  = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	typedef struct packed {
		kind_t              kind;
		logic [63:0]        expiration;
		logic [31:0]        payload_size;
		logic [31:0]        rec_type;
		logic [31:0]        record_flags;
		logic [IDX_W-1:0]   record_index;
		logic [7:0]         payload_byte;
		logic               last_flag;
	} res_t;

endpackage

[sv/record_list_deframer_unit.sv]
// Record list deframer: splits a byte stream into length-prefixed records.
// Input channel: in_valid / in_stall carry data_byte and start_flag, one
// byte per request; start_flag marks the first byte of a new buffer.
// Output channel: out_valid / out_stall carry one result per request:
// a decoded 20-byte header, a payload byte with its record index, or a
// success / failure end result; last_flag marks the final result of a byte.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 total_length, 1 record_count); the user writes only while the block
// is idle, which the block itself does not enforce.
// Path: an accepted byte is held in the input stage; its results then go
// into a four-entry result queue whose head drives the ports. Throughput:
// one byte per cycle while in_stall is low, set by the single-pass
// header/counter update; a byte may give two results, queued together.
// Stall: in_stall rises when the input stage holds a byte and the queue
// has fewer than two free entries; a stalled output holds its result.
// Reset: the queue and input stage empty, parsing waits for a start byte,
// both configuration registers read zero.
module record_list_deframer_unit
	import rld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              start_flag,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic [63:0]       expiration,
	output logic [31:0]       payload_size,
	output logic [31:0]       rec_type,
	output logic [31:0]       record_flags,
	output logic [IDX_W-1:0]  record_index,
	output logic [7:0]        payload_byte,
	output logic              last_flag
);

	logic [LEN_W-1:0] total_q;
	logic [CNT_W-1:0] rcount_q;

	logic        valid_s1;
	logic [7:0]  data_byte_s1;
	logic        start_flag_s1;

	phase_t           phase_q, phase_d, e_phase;
	logic [HBC_W-1:0] hbc_q, hbc_d, e_hbc;
	logic [CNT_W-1:0] rd_q, rd_d, e_rd, rd_inc;
	logic [LEN_W-1:0] off_q, off_d, e_off, new_off;
	logic [END_W-1:0] end_q, end_d, e_end;
	logic [31:0]      rem_q, rem_d, e_rem;
	logic [63:0]      exp_q, exp_d;
	logic [31:0]      size_q, size_d, type_q, type_d, flags_q, flags_d;
	logic             rec_last, oversize, pay_over;

	res_t             r0, r1;
	logic [1:0]       nres, nres_eff;

	res_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FCNT_W-1:0] count_q;
	logic             adv, pop;

	assign adv      = valid_s1 && (count_q <= FCNT_W'(FIFO_DEPTH - 2));
	assign in_stall = valid_s1 && !adv;
	assign out_valid = (count_q != '0);
	assign pop      = out_valid && !out_stall;
	assign nres_eff = adv ? nres : 2'd0;

	assign kind         = fifo_q[rd_ptr_q].kind;
	assign expiration   = fifo_q[rd_ptr_q].expiration;
	assign payload_size = fifo_q[rd_ptr_q].payload_size;
	assign rec_type     = fifo_q[rd_ptr_q].rec_type;
	assign record_flags = fifo_q[rd_ptr_q].record_flags;
	assign record_index = fifo_q[rd_ptr_q].record_index;
	assign payload_byte = fifo_q[rd_ptr_q].payload_byte;
	assign last_flag    = fifo_q[rd_ptr_q].last_flag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			rcount_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TOTAL_LENGTH: total_q  <= cfg_data;
				CFG_RECORD_COUNT: rcount_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_byte_s1  <= data_byte;
			start_flag_s1 <= start_flag;
		end
	end

	always_comb begin
		e_phase = phase_q;
		e_hbc   = hbc_q;
		e_rd    = rd_q;
		e_off   = off_q;
		e_end   = end_q;
		e_rem   = rem_q;
		if (start_flag_s1) begin
			e_phase = PH_HEADER;
			e_hbc   = '0;
			e_rd    = '0;
			e_off   = '0;
			e_end   = END_W'(HDR_BYTES);
			e_rem   = '0;
		end
		rd_inc   = e_rd + 1'b1;
		rec_last = (rd_inc >= rcount_q);
		oversize = (rcount_q > CNT_W'(MAX_RECORDS)) || (total_q > LEN_W'(MAX_BUFFER_BYTES));
		new_off  = e_end[LEN_W-1:0];
		pay_over = (({16'b0, new_off} + {1'b0, size_q}) > {16'b0, total_q});

		phase_d = e_phase;
		hbc_d   = e_hbc;
		rd_d    = e_rd;
		off_d   = e_off;
		end_d   = e_end;
		rem_d   = e_rem;
		exp_d   = exp_q;
		size_d  = size_q;
		type_d  = type_q;
		flags_d = flags_q;
		r0      = '0;
		r1      = '0;
		nres    = 2'd0;

		if (start_flag_s1 && oversize) begin
			r0.kind = KIND_FAILURE;
			nres    = 2'd1;
			phase_d = PH_DONE;
		end else begin
			case (e_phase)
				PH_HEADER: begin
					if (e_hbc == '0 && e_rd >= rcount_q) begin
						r0.kind = KIND_SUCCESS;
						nres    = 2'd1;
						phase_d = PH_DONE;
					end else if (e_hbc == '0 && e_end > {1'b0, total_q}) begin
						r0.kind = KIND_FAILURE;
						nres    = 2'd1;
						phase_d = PH_DONE;
					end else begin
						if (e_hbc < HBC_W'(8)) begin
							exp_d = {exp_q[55:0], data_byte_s1};
						end else if (e_hbc < HBC_W'(12)) begin
							size_d = {size_q[23:0], data_byte_s1};
						end else if (e_hbc < HBC_W'(16)) begin
							type_d = {type_q[23:0], data_byte_s1};
						end else begin
							flags_d = {flags_q[23:0], data_byte_s1};
						end
						if (e_hbc == HBC_W'(HDR_BYTES - 1)) begin
							hbc_d = '0;
							off_d = new_off;
							end_d = {1'b0, new_off} + END_W'(HDR_BYTES);
							if (pay_over) begin
								r0.kind = KIND_FAILURE;
								nres    = 2'd1;
								phase_d = PH_DONE;
							end else begin
								r0.kind         = KIND_HEADER;
								r0.expiration   = exp_d;
								r0.payload_size = size_d;
								r0.rec_type     = type_d;
								r0.record_flags = flags_d;
								r0.record_index = e_rd[IDX_W-1:0];
								nres            = 2'd1;
								if (size_q == '0) begin
									rd_d = rd_inc;
									if (rec_last) begin
										r1.kind = KIND_SUCCESS;
										nres    = 2'd2;
										phase_d = PH_DONE;
									end
								end else begin
									rem_d   = size_q;
									phase_d = PH_PAYLOAD;
								end
							end
						end else begin
							hbc_d = e_hbc + 1'b1;
						end
					end
				end
				PH_PAYLOAD: begin
					r0.kind         = KIND_PAYLOAD;
					r0.record_index = e_rd[IDX_W-1:0];
					r0.payload_byte = data_byte_s1;
					nres            = 2'd1;
					off_d           = e_off + 1'b1;
					end_d = (&e_off) ? END_W'(HDR_BYTES)
						: {1'b0, e_off} + END_W'(HDR_BYTES + 1);
					rem_d = e_rem - 1'b1;
					if (e_rem == 32'd1) begin
						rd_d    = rd_inc;
						hbc_d   = '0;
						phase_d = PH_HEADER;
						if (rec_last) begin
							r1.kind = KIND_SUCCESS;
							nres    = 2'd2;
							phase_d = PH_DONE;
						end
					end
				end
				default: phase_d = PH_DONE;
			endcase
		end

		if (nres == 2'd2) begin
			r1.last_flag = 1'b1;
		end else begin
			r0.last_flag = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			hbc_q   <= '0;
			rd_q    <= '0;
			off_q   <= '0;
			end_q   <= '0;
			rem_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			hbc_q   <= hbc_d;
			rd_q    <= rd_d;
			off_q   <= off_d;
			end_q   <= end_d;
			rem_q   <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			exp_q   <= exp_d;
			size_q  <= size_d;
			type_q  <= type_d;
			flags_q <= flags_d;
		end
	end

	always_ff @(posedge clk) begin
		if (nres_eff != 2'd0) begin
			fifo_q[wr_ptr_q] <= r0;
		end
		if (nres_eff == 2'd2) begin
			fifo_q[wr_ptr_q + 1'b1] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(nres_eff);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + FCNT_W'(nres_eff) - FCNT_W'(pop);
		end
	end

endmodule

[sv/rld_checker.sv]
`include "record_list_deframer_unit_defines.svh"

module rld_checker
	import rld_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [1:0]        kind,
	input logic [63:0]       expiration,
	input logic [31:0]       payload_size,
	input logic [31:0]       rec_type,
	input logic [31:0]       record_flags,
	input logic [IDX_W-1:0]  record_index,
	input logic [7:0]        payload_byte,
	input logic              last_flag
);

	`RLD_ASSERT_RST(a_no_out_in_reset, !arst_n |-> !out_valid, "result during reset")

	`RLD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(kind) && $stable(expiration) && $stable(payload_byte) && $stable(last_flag), "stalled result changed")

	`RLD_ASSERT(a_end_clean, out_valid && (kind == KIND_SUCCESS || kind == KIND_FAILURE) |-> expiration == '0 && payload_size == '0 && record_index == '0 && payload_byte == '0 && last_flag, "end result carries data")

	`RLD_ASSERT(a_payload_clean, out_valid && kind == KIND_PAYLOAD |-> expiration == '0 && payload_size == '0 && rec_type == '0 && record_flags == '0, "payload result carries header")

	`RLD_ASSERT(a_stall_backed, in_stall |-> out_valid, "input stalled with empty queue")

endmodule

bind record_list_deframer_unit rld_checker u_rld_checker (.*);
